[rtl/u8u16_pkg.sv]
// shared types and constants for the utf-8 to utf-16 transcoder
package u8u16_pkg;

  // incoming word: one utf-8 byte plus end-of-string flag
  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } in_word_t;

  // outgoing word: one utf-16 code unit
  typedef struct packed {
    logic [15:0] code_unit;
    logic        run_last;
  } out_word_t;

  // finished code point as queued between front and back
  // pair = 1: value holds point minus 0x10000; pair = 0: value[15:0] is the unit
  typedef struct packed {
    logic        pair;
    logic [19:0] value;
  } cp_entry_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);
  localparam int QCw    = QAw + 1;

  localparam logic [20:0] CpBmpMax   = 21'h00FFFF;
  localparam logic [20:0] CpSuppBase = 21'h010000;
  localparam logic [20:0] CpMax      = 21'h10FFFF;
  localparam logic [15:0] SurrHigh   = 16'hD800;
  localparam logic [15:0] SurrLow    = 16'hDC00;

  localparam logic [1:0] PendNone  = 2'd0;
  localparam logic [1:0] PendOne   = 2'd1;
  localparam logic [1:0] PendTwo   = 2'd2;
  localparam logic [1:0] PendThree = 2'd3;

endpackage

[rtl/u8u16_front.sv]
// front end: accepts bytes, tracks the sequence and queues finished code points
module u8u16_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  u8u16_pkg::in_word_t   din,
  input  u8u16_pkg::q_status_t  q_stat,
  output logic                  full,
  output logic                  q_push,
  output u8u16_pkg::cp_entry_t  q_wdata
);

  logic [1:0]  bytes_pending;
  logic [20:0] code_accum;
  logic [1:0]  bytes_pending_next;
  logic [20:0] code_accum_next;
  logic        take;
  logic        emit;
  logic        accepted;
  logic [20:0] supp_off;

  assign full     = q_stat.full;
  assign accepted = push && !q_stat.full;

  // classify the byte and build the next accumulator
  always_comb begin
    take               = 1'b1;
    bytes_pending_next = bytes_pending;
    code_accum_next    = code_accum;
    if (bytes_pending != u8u16_pkg::PendNone) begin
      code_accum_next    = {code_accum[14:0], din.byte_in[5:0]};
      bytes_pending_next = bytes_pending - 2'd1;
    end else if (din.byte_in[7] == 1'b0) begin
      code_accum_next    = {13'd0, din.byte_in};
    end else if (din.byte_in[7:5] == 3'b110) begin
      code_accum_next    = {16'd0, din.byte_in[4:0]};
      bytes_pending_next = u8u16_pkg::PendOne;
    end else if (din.byte_in[7:4] == 4'b1110) begin
      code_accum_next    = {17'd0, din.byte_in[3:0]};
      bytes_pending_next = u8u16_pkg::PendTwo;
    end else if (din.byte_in[7:3] == 5'b11110) begin
      code_accum_next    = {18'd0, din.byte_in[2:0]};
      bytes_pending_next = u8u16_pkg::PendThree;
    end else begin
      // stray continuation or invalid lead: skipped
      take = 1'b0;
    end
  end

  assign emit = take && ((bytes_pending_next == u8u16_pkg::PendNone) || din.last_byte);

  // queue entry for the finished point
  assign supp_off      = code_accum_next - u8u16_pkg::CpSuppBase;
  assign q_wdata.pair  = code_accum_next > u8u16_pkg::CpBmpMax;
  assign q_wdata.value = q_wdata.pair ? supp_off[19:0] : {4'd0, code_accum_next[15:0]};
  assign q_push        = accepted && emit && (code_accum_next <= u8u16_pkg::CpMax);

  // sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= u8u16_pkg::PendNone;
      code_accum    <= '0;
    end else if (accepted && take) begin
      if (emit) begin
        bytes_pending <= u8u16_pkg::PendNone;
        code_accum    <= '0;
      end else begin
        bytes_pending <= bytes_pending_next;
        code_accum    <= code_accum_next;
      end
    end
  end

  // a queued point never goes into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full) else $error("front pushed into full queue");

  // a queued point is always in range
  a_point_range: assert property (@(posedge clk) disable iff (rst)
    (q_push && q_wdata.pair) |-> (q_wdata.value <= 20'hFFFFF && code_accum_next >= 21'h10000))
    else $error("supplementary point out of range");

  // a pending sequence always holds a nonzero lead bound
  a_pend_after_lead: assert property (@(posedge clk) disable iff (rst)
    (accepted && take && !emit) |=> (bytes_pending != u8u16_pkg::PendNone))
    else $error("pending count lost after lead byte");

endmodule

[rtl/u8u16_queue.sv]
// short queue of finished code points between front and back
module u8u16_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  u8u16_pkg::cp_entry_t  wdata,
  input  logic                  pop,
  output u8u16_pkg::cp_entry_t  rdata,
  output u8u16_pkg::q_status_t  stat
);

  u8u16_pkg::cp_entry_t        slots [u8u16_pkg::QDepth];
  logic [u8u16_pkg::QAw-1:0]   wr_ptr;
  logic [u8u16_pkg::QAw-1:0]   rd_ptr;
  logic [u8u16_pkg::QCw-1:0]   count;
  logic                        push_ok;
  logic                        pop_ok;

  assign stat.full  = count == u8u16_pkg::QCw'(u8u16_pkg::QDepth);
  assign stat.empty = count == '0;
  assign push_ok    = push && !stat.full;
  assign pop_ok     = pop && !stat.empty;
  assign rdata      = slots[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push_ok) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push_ok, pop_ok})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= u8u16_pkg::QCw'(u8u16_pkg::QDepth)) else $error("queue count overflow");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push_ok && !pop_ok) |=> count == $past(count) + 1'b1) else $error("count did not rise");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (wr_ptr - rd_ptr) == count[u8u16_pkg::QAw-1:0]) else $error("pointers and count disagree");

endmodule

[rtl/u8u16_back.sv]
// back end: turns queued code points into utf-16 words behind an output register
module u8u16_back (
  input  logic                  clk,
  input  logic                  rst,
  input  u8u16_pkg::cp_entry_t  q_rdata,
  input  u8u16_pkg::q_status_t  q_stat,
  input  logic                  pop,
  output logic                  q_pop,
  output logic                  empty,
  output u8u16_pkg::out_word_t  dout
);

  logic                  out_valid;
  logic                  half;
  logic                  load;
  logic                  take_head;
  u8u16_pkg::out_word_t  unit_next;

  assign empty     = !out_valid;
  assign load      = !out_valid || pop;
  assign take_head = load && !q_stat.empty;
  assign q_pop     = take_head && (!q_rdata.pair || half);

  // select the unit for the head entry
  always_comb begin
    if (!q_rdata.pair) begin
      unit_next.code_unit = q_rdata.value[15:0];
      unit_next.run_last  = 1'b1;
    end else if (!half) begin
      unit_next.code_unit = u8u16_pkg::SurrHigh | {6'd0, q_rdata.value[19:10]};
      unit_next.run_last  = 1'b0;
    end else begin
      unit_next.code_unit = u8u16_pkg::SurrLow | {6'd0, q_rdata.value[9:0]};
      unit_next.run_last  = 1'b1;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (take_head) begin
      dout <= unit_next;
    end
  end

  // output valid and surrogate half tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      half      <= 1'b0;
    end else if (load) begin
      out_valid <= !q_stat.empty;
      if (take_head) begin
        half <= q_rdata.pair && !half;
      end
    end
  end

  // the low half is still queued while the high half is shown
  a_half_head: assert property (@(posedge clk) disable iff (rst)
    half |-> (!q_stat.empty && q_rdata.pair)) else $error("half set without pair at head");

  a_half_out: assert property (@(posedge clk) disable iff (rst)
    half |-> (out_valid && !dout.run_last)) else $error("half set without high unit shown");

  a_pop_load: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> load) else $error("queue popped while output held");

endmodule

[rtl/utf8_to_utf16_transcoder_core.sv]
// top level of the utf-8 to utf-16 transcoder
//
//  channel   handshake          payload
//  input     push / full        din  : byte_in[7:0], last_byte
//  output    pop / empty        dout : code_unit[15:0], run_last
//
//  one byte is accepted per cycle while the point queue has room
//  a finished point goes to the point queue, then its first unit to the output register
//  a surrogate pair leaves the output as two units, the high one before the low one
//  the point queue holds four points; input goes on while output stalls until it fills
//  rst is synchronous and clears sequence state, queue pointers and output valid state
module utf8_to_utf16_transcoder_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  u8u16_pkg::in_word_t   din,
  output logic                  full,
  input  logic                  pop,
  output logic                  empty,
  output u8u16_pkg::out_word_t  dout
);

  u8u16_pkg::q_status_t  q_stat;
  u8u16_pkg::cp_entry_t  q_wdata;
  u8u16_pkg::cp_entry_t  q_rdata;
  logic                  q_push;
  logic                  q_pop;

  // byte classification and accumulation
  u8u16_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .din     (din),
    .q_stat  (q_stat),
    .full    (full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  // point queue
  u8u16_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // unit generation and output register
  u8u16_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_rdata (q_rdata),
    .q_stat  (q_stat),
    .pop     (pop),
    .q_pop   (q_pop),
    .empty   (empty),
    .dout    (dout)
  );

endmodule

[tb/testbench.sv]
// testbench for the utf-8 to utf-16 transcoder core
`timescale 1ns / 100ps

module testbench;

  localparam int ByteTarget = 750;
  localparam int HoldCycles = 120;
  localparam int SettleCycles = 8;
  localparam int StallLimit = 2000;

  // expected utf-16 units, predicted from the accepted byte stream
  class utf16_unit_board;
    u8u16_pkg::out_word_t units[$];
    int                   fails;
    logic [1:0]           pend;
    logic [20:0]          accum;

    function new();
      fails = 0;
      pend = u8u16_pkg::PendNone;
      accum = '0;
    endfunction

    // decode one accepted byte; returns 0 when the byte is skipped
    function bit note_byte(u8u16_pkg::in_word_t w);
      logic [7:0]           b;
      logic [20:0]          cp;
      logic [20:0]          v;
      u8u16_pkg::out_word_t u;
      b = w.byte_in;
      if (pend != u8u16_pkg::PendNone) begin
        // any byte counts as continuation while a sequence is open
        accum = {accum[14:0], b[5:0]};
        pend = pend - 2'd1;
      end else if (b[7] == 1'b0) begin
        accum = {13'd0, b};
      end else if (b[7:5] == 3'b110) begin
        accum = {16'd0, b[4:0]};
        pend = u8u16_pkg::PendOne;
      end else if (b[7:4] == 4'b1110) begin
        accum = {17'd0, b[3:0]};
        pend = u8u16_pkg::PendTwo;
      end else if (b[7:3] == 5'b11110) begin
        accum = {18'd0, b[2:0]};
        pend = u8u16_pkg::PendThree;
      end else begin
        // stray continuation or invalid lead
        return 1'b0;
      end
      if (pend == u8u16_pkg::PendNone || w.last_byte) begin
        cp = accum;
        pend = u8u16_pkg::PendNone;
        accum = '0;
        if (cp <= u8u16_pkg::CpBmpMax) begin
          u.code_unit = cp[15:0];
          u.run_last = 1'b1;
          units = {units, u};
        end else if (cp <= u8u16_pkg::CpMax) begin
          v = cp - u8u16_pkg::CpSuppBase;
          u.code_unit = u8u16_pkg::SurrHigh | {6'd0, v[19:10]};
          u.run_last = 1'b0;
          units = {units, u};
          u.code_unit = u8u16_pkg::SurrLow | {6'd0, v[9:0]};
          u.run_last = 1'b1;
          units = {units, u};
        end
      end
      return 1'b1;
    endfunction

    // compare one popped word with the oldest expected unit
    function void check_unit(u8u16_pkg::out_word_t got);
      u8u16_pkg::out_word_t want;
      if (units.size() == 0) begin
        $error("unexpected word: code_unit %h run_last %b", got.code_unit, got.run_last);
        fails++;
        return;
      end
      want = units.pop_front();
      if (got.code_unit !== want.code_unit) begin
        $error("code_unit: expected %h, actual %h", want.code_unit, got.code_unit);
        fails++;
      end
      if (got.run_last !== want.run_last) begin
        $error("run_last: expected %b, actual %b", want.run_last, got.run_last);
        fails++;
      end
    endfunction

    function int waiting();
      return units.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  u8u16_pkg::in_word_t  din = '0;
  logic                 full;
  logic                 pop = 1'b0;
  logic                 empty;
  u8u16_pkg::out_word_t dout;

  utf16_unit_board board;
  int bytes_used = 0;
  bit idle_off = 1'b0;
  bit hold_req = 1'b0;

  utf8_to_utf16_transcoder_core DUT (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (din),
    .full  (full),
    .pop   (pop),
    .empty (empty),
    .dout  (dout)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // offer one byte, with random gaps, until the block takes it
  task automatic send_byte(input logic [7:0] b, input logic last);
    u8u16_pkg::in_word_t w;
    bit                  taken;
    w.byte_in = b;
    w.last_byte = last;
    while (!idle_off && $urandom_range(0, 99) < 29) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    din <= w;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !full;
      if (taken && board.note_byte(w))
        bytes_used++;
      @(posedge clk);
    end
  endtask

  // one utf-8 sequence of nbytes, cut after keep bytes
  task automatic send_point(input int nbytes, input int keep, input logic last);
    logic [7:0] b;
    for (int i = 0; i < keep; i++) begin
      if (i == 0) begin
        case (nbytes)
          1: b = 8'($urandom_range(0, 127));
          2: b = 8'(8'hC0 + $urandom_range(0, 31));
          3: b = 8'(8'hE0 + $urandom_range(0, 15));
          default: b = 8'(8'hF0 + $urandom_range(0, 7));
        endcase
      end else if ($urandom_range(0, 9) == 0) begin
        b = 8'($urandom_range(0, 255));
      end else begin
        b = 8'(8'h80 + $urandom_range(0, 63));
      end
      send_byte(b, last && (i == keep - 1));
    end
  endtask

  // a short string: mostly well-formed points, some noise and cut sequences
  task automatic send_random_string();
    int   n;
    int   kind;
    int   len;
    logic endp;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 99);
      endp = (i == n - 1);
      if (kind < 10) begin
        case ($urandom_range(0, 2))
          0: send_byte(8'(8'h80 + $urandom_range(0, 63)), endp);
          1: send_byte(8'(8'hF8 + $urandom_range(0, 7)), endp);
          default: send_byte(8'($urandom_range(0, 255)), endp);
        endcase
      end else if (kind < 20) begin
        len = $urandom_range(2, 4);
        send_point(len, $urandom_range(1, len - 1), 1'b1);
        break;
      end else begin
        len = $urandom_range(1, 4);
        send_point(len, len, endp);
      end
    end
  endtask

  // hold the input until every expected unit has come out
  task automatic drain_results();
    push <= 1'b0;
    while (board.waiting() != 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // receiver: random pops, one long hold-off on request
  initial begin
    int                   hold_left;
    logic                 pop_next;
    u8u16_pkg::out_word_t got;
    hold_left = 0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_left > 0) begin
        hold_left--;
        pop_next = 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles;
        pop_next = 1'b0;
      end else begin
        pop_next = idle_off || ($urandom_range(0, 99) >= 29);
      end
      pop <= pop_next;
      @(negedge clk);
      if (pop && !empty) begin
        got = dout;
        board.check_unit(got);
      end
      @(posedge clk);
    end
  end

  // watchdog on cycles with no word moving on either side
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(negedge clk);
      if (rst || (push && !full) || (pop && !empty))
        quiet = 0;
      else
        quiet++;
      if (quiet >= StallLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    bit hold_done;
    bit drain_done;
    board = new();
    hold_done = 1'b0;
    drain_done = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ascii extremes, last flag on a single byte
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    // overlong two-byte form of zero
    send_byte(8'hC0, 1'b0);
    send_byte(8'h80, 1'b0);
    // three-byte point
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    // lowest and highest surrogate pair
    send_byte(8'hF0, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hF4, 1'b0);
    send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    // point above the unicode range is dropped
    send_byte(8'hF7, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    // stray continuation, invalid leads, last flag on a skipped byte
    send_byte(8'h80, 1'b0);
    send_byte(8'hF8, 1'b0);
    send_byte(8'hFF, 1'b1);
    // string ends inside a sequence
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
    // lead-looking byte taken as continuation
    send_byte(8'hC3, 1'b0);
    send_byte(8'hC3, 1'b0);

    // random strings
    while (bytes_used < ByteTarget) begin
      if (!hold_done && bytes_used >= 150) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && bytes_used >= 400) begin
        drain_results();
        drain_done = 1'b1;
      end
      idle_off = (bytes_used >= 450 && bytes_used < 600);
      send_random_string();
    end
    idle_off = 1'b0;

    // wrap up
    push <= 1'b0;
    while (board.waiting() != 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (board.fails == 0 && board.waiting() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
